FILE: design/i2c_trf_pkg.sv
// shared types and constants of the i2c target register file
`timescale 1ns / 1ps

package i2c_trf_pkg;

    localparam int unsigned NUM_REGS   = 5;
    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned REG_W      = 32;

    localparam int unsigned PTR_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int unsigned BLEFT_W = $clog2(WORD_BYTES + 1);
    localparam int unsigned SHIFT_W = (8 * WORD_BYTES > REG_W) ? 8 * WORD_BYTES : REG_W;

    localparam int unsigned REG_SETTING = 1;
    localparam int unsigned REG_TEST    = 4;

    // field widths on the stream ports
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned M_TUSER_W = 1;

    typedef logic [REG_W-1:0]   t_word;
    typedef logic [SHIFT_W-1:0] t_shift;
    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [BLEFT_W-1:0] t_bleft;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_POINTER       = 3'd1,
        PH_READ_OR_WRITE = 3'd2,
        PH_WRITING       = 3'd3,
        PH_READING       = 3'd4,
        PH_FINISHED      = 3'd5,
        PH_ERROR         = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CMD_WRITE_START = 2'd0,
        CMD_WRITE_BYTE  = 2'd1,
        CMD_READ_BYTE   = 2'd2,
        CMD_LOCAL_WRITE = 2'd3
    } t_cmd;

endpackage

FILE: design/i2c_target_register_file_unit.sv
// byte-level i2c target holding a small file of 32-bit registers
//
// input stream: one word per bus event. tuser carries the command (write
// start, written byte, read request, local update); tdata carries the bus
// byte, the local register index and the local value.
// output stream: one word per input word, in order. tdata carries the byte
// read back (zero unless a read), then the setting register 1 and the test
// register 4 as they stand after the event; tuser carries the refuse flag.
// a pointer byte after a write start selects a register; four more written
// bytes form a little-endian word stored in register 1 or 4 only, the last
// byte being refused. reads return the selected register lsb first, then one
// extra read returns zero.
// the result is registered and appears in the cycle after the input word is taken.
// throughput: one word per cycle unless the receiver stalls; phase, pointer, byte
// counter and the register file are all updated in the accept cycle from the registered state.
// the single output register frees itself when the receiver takes its word,
// so the input is ready whenever that register is empty or being drained.
// when the receiver stalls, the result holds and the input is stalled too.
// reset (synchronous, active low) clears the phase to idle, the pointer, the
// counter and all registers to zero, and empties the output register.
`timescale 1ns / 1ps

module i2c_target_register_file_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // bus_byte[7:0], local_index[10:8], local_value[42:11], zero pad
    input  logic [i2c_trf_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // command[1:0]
    input  logic [i2c_trf_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // read_byte[7:0], setting_word[39:8], test_word[71:40]
    output logic [i2c_trf_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // refused[0]
    output logic [i2c_trf_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    // registered state
    i2c_trf_pkg::t_phase r_phase, n_phase;
    i2c_trf_pkg::t_ptr   r_pointer, n_pointer;
    i2c_trf_pkg::t_bleft r_bytes_left, n_bytes_left;
    i2c_trf_pkg::t_shift r_shift, n_shift;
    i2c_trf_pkg::t_word  r_regs [i2c_trf_pkg::NUM_REGS];
    i2c_trf_pkg::t_word  n_regs [i2c_trf_pkg::NUM_REGS];

    // output register
    logic                      r_m_valid;
    logic [7:0]                r_read_byte, n_read_byte;
    logic                      r_refused, n_refused;
    i2c_trf_pkg::t_word        r_setting, n_setting;
    i2c_trf_pkg::t_word        r_test, n_test;

    // input fields
    i2c_trf_pkg::t_cmd  s_cmd;
    logic [7:0]         s_bus_byte;
    logic [2:0]         s_local_index;
    i2c_trf_pkg::t_word s_local_value;
    logic               s_acc;

    assign s_cmd         = i2c_trf_pkg::t_cmd'(i_s_tuser);
    assign s_bus_byte    = i_s_tdata[7:0];
    assign s_local_index = i_s_tdata[10:8];
    assign s_local_value = i_s_tdata[42:11];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        i2c_trf_pkg::t_shift sw;
        i2c_trf_pkg::t_bleft bl;
        logic                writable;

        n_phase      = r_phase;
        n_pointer    = r_pointer;
        n_bytes_left = r_bytes_left;
        n_shift      = r_shift;
        n_regs       = r_regs;
        n_read_byte  = 8'h00;
        n_refused    = 1'b0;
        sw           = r_shift;
        bl           = r_bytes_left;
        writable     = (32'(r_pointer) == i2c_trf_pkg::REG_SETTING) ||
                       (32'(r_pointer) == i2c_trf_pkg::REG_TEST);

        unique case (s_cmd)
            i2c_trf_pkg::CMD_WRITE_START: begin
                n_phase = i2c_trf_pkg::PH_POINTER;
            end
            i2c_trf_pkg::CMD_WRITE_BYTE: begin
                case (r_phase)
                    i2c_trf_pkg::PH_POINTER: begin
                        if (32'(s_bus_byte) < i2c_trf_pkg::NUM_REGS) begin
                            n_pointer = i2c_trf_pkg::PTR_W'(s_bus_byte);
                            n_phase   = i2c_trf_pkg::PH_READ_OR_WRITE;
                        end else begin
                            n_phase   = i2c_trf_pkg::PH_ERROR;
                            n_refused = 1'b1;
                        end
                    end
                    i2c_trf_pkg::PH_READ_OR_WRITE, i2c_trf_pkg::PH_WRITING: begin
                        if (r_phase == i2c_trf_pkg::PH_READ_OR_WRITE) begin
                            sw = '0;
                            bl = i2c_trf_pkg::BLEFT_W'(i2c_trf_pkg::WORD_BYTES);
                        end
                        // new byte enters at the top of the word, little-endian
                        sw = (sw >> 8) | (i2c_trf_pkg::SHIFT_W'(s_bus_byte)
                                          << (8 * (i2c_trf_pkg::WORD_BYTES - 1)));
                        n_phase = i2c_trf_pkg::PH_WRITING;
                        if (bl > i2c_trf_pkg::BLEFT_W'(1)) begin
                            bl = bl - i2c_trf_pkg::BLEFT_W'(1);
                        end else begin
                            bl        = '0;
                            n_phase   = i2c_trf_pkg::PH_IDLE;
                            n_refused = 1'b1;
                            if (writable) begin
                                n_regs[r_pointer] = sw[i2c_trf_pkg::REG_W-1:0];
                            end
                        end
                        n_shift      = sw;
                        n_bytes_left = bl;
                    end
                    default: begin
                        n_phase   = i2c_trf_pkg::PH_ERROR;
                        n_refused = 1'b1;
                    end
                endcase
            end
            i2c_trf_pkg::CMD_READ_BYTE: begin
                case (r_phase)
                    i2c_trf_pkg::PH_READ_OR_WRITE, i2c_trf_pkg::PH_READING: begin
                        if (r_phase == i2c_trf_pkg::PH_READ_OR_WRITE) begin
                            sw = i2c_trf_pkg::SHIFT_W'(r_regs[r_pointer]);
                            bl = i2c_trf_pkg::BLEFT_W'(i2c_trf_pkg::WORD_BYTES);
                        end
                        n_read_byte = sw[7:0];
                        sw          = sw >> 8;
                        n_phase     = i2c_trf_pkg::PH_READING;
                        if (bl > i2c_trf_pkg::BLEFT_W'(1)) begin
                            bl = bl - i2c_trf_pkg::BLEFT_W'(1);
                        end else begin
                            bl      = '0;
                            n_phase = i2c_trf_pkg::PH_FINISHED;
                        end
                        n_shift      = sw;
                        n_bytes_left = bl;
                    end
                    i2c_trf_pkg::PH_FINISHED: begin
                        // overread returns zero and closes the transfer
                        n_phase = i2c_trf_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase   = i2c_trf_pkg::PH_ERROR;
                        n_refused = 1'b1;
                    end
                endcase
            end
            i2c_trf_pkg::CMD_LOCAL_WRITE: begin
                if (32'(s_local_index) < i2c_trf_pkg::NUM_REGS) begin
                    n_regs[i2c_trf_pkg::PTR_W'(s_local_index)] = s_local_value;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        n_setting = n_regs[i2c_trf_pkg::PTR_W'(i2c_trf_pkg::REG_SETTING)];
        n_test    = (i2c_trf_pkg::REG_TEST < i2c_trf_pkg::NUM_REGS) ?
                    n_regs[i2c_trf_pkg::PTR_W'(i2c_trf_pkg::REG_TEST)] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2c_trf_pkg::PH_IDLE;
            r_pointer    <= '0;
            r_bytes_left <= '0;
            r_shift      <= '0;
            for (int i = 0; i < i2c_trf_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (s_acc) begin
            r_phase      <= n_phase;
            r_pointer    <= n_pointer;
            r_bytes_left <= n_bytes_left;
            r_shift      <= n_shift;
            r_regs       <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_acc) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_read_byte <= n_read_byte;
            r_refused   <= n_refused;
            r_setting   <= n_setting;
            r_test      <= n_test;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_test, r_setting, r_read_byte};
    assign o_m_tuser  = r_refused;

    // a refused word never carries read data
    a_refused_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_refused) |-> (r_read_byte == 8'h00))
        else $error("refused word carries a nonzero read byte");

    // a transfer in progress always has bytes to go
    a_writing_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2c_trf_pkg::PH_WRITING || r_phase == i2c_trf_pkg::PH_READING)
        |-> (r_bytes_left != '0))
        else $error("transfer phase with empty byte count");

    // a local update of the setting register shows up in the next result
    a_local_setting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_cmd == i2c_trf_pkg::CMD_LOCAL_WRITE &&
         32'(s_local_index) == i2c_trf_pkg::REG_SETTING)
        |=> (r_setting == $past(s_local_value)))
        else $error("local update of the setting register lost");

    // the output register only refills when it is empty or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |-> !s_acc)
        else $error("pending result overwritten");

endmodule

FILE: sim/tb_i2c_target_register_file_unit.sv
// testbench for the i2c target register file: random and directed bus events vs a predictor
`timescale 1ns / 1ps

module tb_i2c_target_register_file_unit;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0]         read_byte;
        logic               refused;
        i2c_trf_pkg::t_word setting_word;
        i2c_trf_pkg::t_word test_word;
    } t_file_response;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_s_tvalid;
    logic                                o_s_tready;
    logic [i2c_trf_pkg::S_TDATA_W-1:0]   i_s_tdata;
    logic [i2c_trf_pkg::S_TUSER_W-1:0]   i_s_tuser;
    logic                                o_m_tvalid;
    logic                                i_m_tready = 1'b0;
    logic [i2c_trf_pkg::M_TDATA_W-1:0]   o_m_tdata;
    logic [i2c_trf_pkg::M_TUSER_W-1:0]   o_m_tuser;

    // predictor state
    i2c_trf_pkg::t_phase bus_phase;
    int unsigned         sel_reg;
    int                  byte_count;
    i2c_trf_pkg::t_shift shift_acc;
    i2c_trf_pkg::t_word  reg_file [i2c_trf_pkg::NUM_REGS];

    t_file_response pending_responses[$];
    int             mismatches = 0;
    int             events_sent = 0;
    int             send_idle_pct = 10;
    int             rcv_idle_pct = 85;
    int             hold_request = 0;
    int             hold_left = 0;
    int             quiet_cycles = 0;

    i2c_target_register_file_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic i2c_trf_pkg::t_word stored_word(int unsigned idx);
        return (idx < i2c_trf_pkg::NUM_REGS) ? reg_file[idx] : '0;
    endfunction

    function automatic void clear_register_file();
        bus_phase  = i2c_trf_pkg::PH_IDLE;
        sel_reg    = 0;
        byte_count = 0;
        shift_acc  = '0;
        for (int i = 0; i < i2c_trf_pkg::NUM_REGS; i++) begin
            reg_file[i] = '0;
        end
    endfunction

    function automatic t_file_response apply_bus_event(i2c_trf_pkg::t_cmd cmd,
                                                       logic [7:0] b, logic [2:0] idx,
                                                       i2c_trf_pkg::t_word val);
        t_file_response r;
        r.read_byte = '0;
        r.refused   = 1'b0;
        case (cmd)
            i2c_trf_pkg::CMD_WRITE_START: begin
                bus_phase = i2c_trf_pkg::PH_POINTER;
            end
            i2c_trf_pkg::CMD_WRITE_BYTE: begin
                case (bus_phase)
                    i2c_trf_pkg::PH_POINTER: begin
                        if (b < i2c_trf_pkg::NUM_REGS) begin
                            sel_reg   = b;
                            bus_phase = i2c_trf_pkg::PH_READ_OR_WRITE;
                        end else begin
                            bus_phase = i2c_trf_pkg::PH_ERROR;
                            r.refused = 1'b1;
                        end
                    end
                    i2c_trf_pkg::PH_READ_OR_WRITE, i2c_trf_pkg::PH_WRITING: begin
                        if (bus_phase == i2c_trf_pkg::PH_READ_OR_WRITE) begin
                            bus_phase  = i2c_trf_pkg::PH_WRITING;
                            shift_acc  = '0;
                            byte_count = i2c_trf_pkg::WORD_BYTES;
                        end
                        shift_acc = (shift_acc >> 8) |
                                    (i2c_trf_pkg::t_shift'(b)
                                     << (8 * (i2c_trf_pkg::WORD_BYTES - 1)));
                        if (byte_count > 1) begin
                            byte_count--;
                        end else begin
                            byte_count = 0;
                            // only the setting and test registers take bus writes
                            if ((sel_reg == i2c_trf_pkg::REG_SETTING ||
                                 sel_reg == i2c_trf_pkg::REG_TEST) &&
                                sel_reg < i2c_trf_pkg::NUM_REGS) begin
                                reg_file[sel_reg] = shift_acc[i2c_trf_pkg::REG_W-1:0];
                            end
                            bus_phase = i2c_trf_pkg::PH_IDLE;
                            r.refused = 1'b1;
                        end
                    end
                    default: begin
                        bus_phase = i2c_trf_pkg::PH_ERROR;
                        r.refused = 1'b1;
                    end
                endcase
            end
            i2c_trf_pkg::CMD_READ_BYTE: begin
                case (bus_phase)
                    i2c_trf_pkg::PH_READ_OR_WRITE, i2c_trf_pkg::PH_READING: begin
                        if (bus_phase == i2c_trf_pkg::PH_READ_OR_WRITE) begin
                            bus_phase  = i2c_trf_pkg::PH_READING;
                            shift_acc  = i2c_trf_pkg::t_shift'(stored_word(sel_reg));
                            byte_count = i2c_trf_pkg::WORD_BYTES;
                        end
                        r.read_byte = shift_acc[7:0];
                        shift_acc   = shift_acc >> 8;
                        if (byte_count > 1) begin
                            byte_count--;
                        end else begin
                            byte_count = 0;
                            bus_phase  = i2c_trf_pkg::PH_FINISHED;
                        end
                    end
                    i2c_trf_pkg::PH_FINISHED: begin
                        // overread returns zero and goes idle
                        bus_phase = i2c_trf_pkg::PH_IDLE;
                    end
                    default: begin
                        bus_phase = i2c_trf_pkg::PH_ERROR;
                        r.refused = 1'b1;
                    end
                endcase
            end
            default: begin
                if (idx < i2c_trf_pkg::NUM_REGS) begin
                    reg_file[idx] = val;
                end
            end
        endcase
        r.setting_word = stored_word(i2c_trf_pkg::REG_SETTING);
        r.test_word    = stored_word(i2c_trf_pkg::REG_TEST);
        return r;
    endfunction

    task automatic offer_event(i2c_trf_pkg::t_cmd cmd, logic [7:0] b, logic [2:0] idx,
                               i2c_trf_pkg::t_word val);
        bit ready_seen;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {5'b0, val, idx, b};
        do begin
            @(negedge i_clk);
            ready_seen = o_s_tready;
            @(posedge i_clk);
        end while (!ready_seen);
        pending_responses.push_back(apply_bus_event(cmd, b, idx, val));
        events_sent++;
    endtask

    function automatic i2c_trf_pkg::t_word random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_transaction();
        int         kind;
        int         len;
        logic [7:0] ptr;
        kind = $urandom_range(0, 99);
        ptr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, i2c_trf_pkg::NUM_REGS - 1));
        if (kind < 40) begin
            offer_event(i2c_trf_pkg::CMD_WRITE_START, 8'($urandom), 3'($urandom), $urandom);
            offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, ptr, 3'($urandom), $urandom);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6)
                                              : i2c_trf_pkg::WORD_BYTES;
            repeat (len) begin
                offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'(random_word()),
                            3'($urandom), $urandom);
            end
        end else if (kind < 70) begin
            offer_event(i2c_trf_pkg::CMD_WRITE_START, 8'($urandom), 3'($urandom), $urandom);
            offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, ptr, 3'($urandom), $urandom);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                              : i2c_trf_pkg::WORD_BYTES + 1;
            repeat (len) begin
                offer_event(i2c_trf_pkg::CMD_READ_BYTE, 8'($urandom), 3'($urandom),
                            $urandom);
            end
        end else if (kind < 85) begin
            offer_event(i2c_trf_pkg::CMD_LOCAL_WRITE, 8'($urandom),
                        3'($urandom_range(0, 7)), random_word());
        end else begin
            offer_event(i2c_trf_pkg::t_cmd'($urandom_range(0, 3)), 8'(random_word()),
                        3'($urandom), random_word());
        end
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        send_idle_pct = sender_pct;
        rcv_idle_pct  = receiver_pct;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        // read while idle, then a byte while in error
        offer_event(i2c_trf_pkg::CMD_READ_BYTE, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_START, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'(i2c_trf_pkg::REG_SETTING), 3'd0, '0);
        repeat (i2c_trf_pkg::WORD_BYTES) begin
            offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'hff, 3'd7, '1);
        end
        // pointer out of range
        offer_event(i2c_trf_pkg::CMD_WRITE_START, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'(i2c_trf_pkg::NUM_REGS), 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_LOCAL_WRITE, 8'h00, 3'd0, '1);
        // ignored index
        offer_event(i2c_trf_pkg::CMD_LOCAL_WRITE, 8'h00, 3'd7, 32'h1234_5678);
        // read-only register 0, then a read while writing
        offer_event(i2c_trf_pkg::CMD_WRITE_START, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'h12, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_READ_BYTE, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_START, 8'h00, 3'd0, '0);
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'(i2c_trf_pkg::REG_SETTING), 3'd0, '0);
        // last one is the overread
        repeat (i2c_trf_pkg::WORD_BYTES + 1) begin
            offer_event(i2c_trf_pkg::CMD_READ_BYTE, 8'h00, 3'd0, '0);
        end
        // byte after going idle
        offer_event(i2c_trf_pkg::CMD_WRITE_BYTE, 8'h00, 3'd0, '0);
    endtask

    task automatic test_random(int count);
        int goal;
        goal = events_sent + count;
        while (events_sent < goal) begin
            random_transaction();
        end
    endtask

    task automatic test_backpressure();
        int goal;
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        hold_request = HOLD_CYCLES;
        @(posedge i_clk);
        goal = events_sent + 30;
        while (events_sent < goal) begin
            random_transaction();
        end
    endtask

    task automatic test_drain_pause();
        i_s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        test_random(20);
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // response checker, sampled mid-cycle so the handshake is stable
    always @(negedge i_clk) begin : response_check
        t_file_response want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h / %h",
                         $time, o_m_tdata, o_m_tuser);
                mismatches++;
            end else begin
                want = pending_responses.pop_front();
                if (o_m_tdata[7:0] !== want.read_byte) begin
                    $display("%0t: read_byte expected %h, actual %h",
                             $time, want.read_byte, o_m_tdata[7:0]);
                    mismatches++;
                end
                if (o_m_tuser[0] !== want.refused) begin
                    $display("%0t: refused expected %h, actual %h",
                             $time, want.refused, o_m_tuser[0]);
                    mismatches++;
                end
                if (o_m_tdata[39:8] !== want.setting_word) begin
                    $display("%0t: setting_word expected %h, actual %h",
                             $time, want.setting_word, o_m_tdata[39:8]);
                    mismatches++;
                end
                if (o_m_tdata[71:40] !== want.test_word) begin
                    $display("%0t: test_word expected %h, actual %h",
                             $time, want.test_word, o_m_tdata[71:40]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        clear_register_file();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(200);
        test_backpressure();
        test_drain_pause();
        set_idling(85, 10);
        test_random(200);
        set_idling(0, 0);
        test_random(200);

        i_s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && pending_responses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/i2c_trf_pkg.sv
design/i2c_target_register_file_unit.sv
sim/tb_i2c_target_register_file_unit.sv
